// ===== hdl/arpc_pkg.sv =====
package arpc_pkg;

  // Field and register widths
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CTR_W      = 14;
  localparam int unsigned RAD_W      = 12;
  localparam int unsigned CANVAS_W   = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned FG_LSB     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Distance arithmetic
  localparam int unsigned CMP_W = (COORD_W > CANVAS_W) ? COORD_W : CANVAS_W;
  localparam int unsigned DX_W  = ((COORD_W > CTR_W - 1) ? COORD_W : CTR_W - 1) + 2;
  localparam int unsigned MAG_W = DX_W - 1;
  localparam int unsigned SQ_W  = 2 * MAG_W;
  localparam int unsigned D_W   = SQ_W + 1;
  localparam int unsigned SQR_W = 2 * RAD_W;

  // Alpha ramp: t = offset * 256 / range, t in [0, 256]
  localparam int unsigned SCALE_SH = 8;
  localparam int unsigned OFF_W    = RAD_W + 1;
  localparam int unsigned DIV_W    = RAD_W + 1;
  localparam int unsigned NUM_W    = OFF_W + SCALE_SH;
  localparam int unsigned Q_W      = SCALE_SH + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_OUTER_RADIUS  = 3'd2,
    CFG_RING_WIDTH    = 3'd3,
    CFG_DRAW_COLOR    = 3'd4,
    CFG_CANVAS_WIDTH  = 3'd5,
    CFG_CANVAS_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REGION_OUTER,
    REGION_INNER,
    REGION_SOLID
  } region_e;

  // Sideband carried alongside the divider
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    region_e            region;
  } side_t;

endpackage

// ===== hdl/arpc_divider.sv =====
module arpc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [arpc_pkg::NUM_W-1:0]  num_i,
  input  logic [arpc_pkg::DIV_W-1:0]  den_i,
  input  arpc_pkg::side_t             side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [arpc_pkg::Q_W-1:0]    quot_o,
  output arpc_pkg::side_t             side_o
);
  import arpc_pkg::*;

  // One quotient bit per stage, most significant first
  localparam int unsigned NSTG = Q_W;

  logic             v_q    [NSTG];
  logic [NSTG:0]    rdy;
  logic [NUM_W-1:0] rem_q  [NSTG];
  logic [Q_W-1:0]   quot_q [NSTG];
  logic [DIV_W-1:0] den_q  [NSTG];
  side_t            side_q [NSTG];

  assign rdy[NSTG] = out_ready_i;

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam int unsigned SH = NSTG - 1 - j;

    logic             vin;
    logic [NUM_W-1:0] rin;
    logic [Q_W-1:0]   qin;
    logic [DIV_W-1:0] din;
    side_t            sin;
    logic [NUM_W-1:0] dsh;
    logic [NUM_W:0]   trial;
    logic [Q_W-1:0]   quot_d;
    logic [NUM_W-1:0] rem_d;

    if (j == 0) begin : g_first
      assign vin = in_valid_i;
      assign rin = num_i;
      assign qin = '0;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = quot_q[j-1];
      assign din = den_q[j-1];
      assign sin = side_q[j-1];
    end

    // stage may load when empty or when its successor takes its contents
    assign rdy[j] = !v_q[j] || rdy[j+1];

    // trial subtract of the shifted divisor
    assign dsh   = {{(NUM_W - DIV_W){1'b0}}, din} << SH;
    assign trial = {1'b0, rin} - {1'b0, dsh};

    always_comb begin
      quot_d     = qin;
      quot_d[SH] = !trial[NUM_W];
      rem_d      = trial[NUM_W] ? rin : trial[NUM_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vin) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
        den_q[j]  <= din;
        side_q[j] <= sin;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG-1];
  assign quot_o      = quot_q[NSTG-1];
  assign side_o      = side_q[NSTG-1];

endmodule

// ===== hdl/antialiased_ring_pixel_coverage.sv =====
// Anti-aliased ring coverage for a stream of pixel coordinates.
// Configuration: write a register index and data on cfg_valid_i/cfg_index_i/
// cfg_data_i; cfg_ready_o is always high, so each valid cycle is a transfer.
// Registers: centre x/y, outer radius, ring width, ARGB colour, canvas size.
// Write them only while no pixel is in flight.
// Input: one pixel coordinate per transfer on in_valid_i/pos_x_i/pos_y_i,
// taken when in_stall_o is low. Output: one pixel to draw per transfer on
// out_valid_o, taken when out_stall_i is low, carrying its coordinate, the
// write mode (0 plain write, 1 blend) and the coverage alpha.
// Pixels that are off canvas, outside the ring or of zero alpha give nothing.
// Throughput: one pixel per clock while out_stall_i is low. Pipeline: four
// distance/classify stages, the nine-stage restoring divider for the ramp
// (one quotient bit per stage) and two alpha stages. Each stage holds its
// item when the one after it is full and stalled, so bubbles are squeezed
// out and a stall loses nothing; in_stall_o rises only once every stage is
// occupied.
// Reset clears the configuration registers to zero (drawing disabled) and empties the pipe.
module antialiased_ring_pixel_coverage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [arpc_pkg::COORD_W-1:0]     pos_x_i,
  input  logic [arpc_pkg::COORD_W-1:0]     pos_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [arpc_pkg::COORD_W-1:0]     out_x_o,
  output logic [arpc_pkg::COORD_W-1:0]     out_y_o,
  output logic                             write_mode_o,
  output logic [arpc_pkg::ALPHA_W-1:0]     coverage_alpha_o
);
  import arpc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CTR_W-1:0]    center_x_q, center_y_q;
  logic [RAD_W-1:0]    outer_radius_q, ring_width_q;
  logic [COLOR_W-1:0]  draw_color_q;
  logic [CANVAS_W-1:0] canvas_width_q, canvas_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      outer_radius_q  <= '0;
      ring_width_q    <= '0;
      draw_color_q    <= '0;
      canvas_width_q  <= '0;
      canvas_height_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CENTER_X:      center_x_q      <= cfg_data_i[CTR_W-1:0];
        CFG_CENTER_Y:      center_y_q      <= cfg_data_i[CTR_W-1:0];
        CFG_OUTER_RADIUS:  outer_radius_q  <= cfg_data_i[RAD_W-1:0];
        CFG_RING_WIDTH:    ring_width_q    <= cfg_data_i[RAD_W-1:0];
        CFG_DRAW_COLOR:    draw_color_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i[CANVAS_W-1:0];
        CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data_i[CANVAS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived ring geometry, two register levels; settles before the first
  // pixel after a write reaches the classify stage
  logic [RAD_W-1:0] rw_lim, rw_clamp;
  logic [RAD_W-1:0] r_a_q, ri_a_q, ri_a_d, ri_m1;
  logic [SQR_W-1:0] outer_sq_q, outer_aa_q, inner_sq_q, inner_aa_q;
  logic [SQR_W-1:0] outer_sq_d;
  logic [DIV_W-1:0] outer_div_q, inner_div_q;

  // ring width clamped to half the radius
  assign rw_lim   = outer_radius_q >> 1;
  assign rw_clamp = (ring_width_q > rw_lim) ? rw_lim : ring_width_q;
  assign ri_a_d   = outer_radius_q - rw_clamp;
  assign ri_m1    = ri_a_q - RAD_W'(1);

  assign outer_sq_d = {{RAD_W{1'b0}}, r_a_q} * {{RAD_W{1'b0}}, r_a_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_a_q       <= '0;
      ri_a_q      <= '0;
      outer_sq_q  <= '0;
      outer_aa_q  <= '0;
      inner_sq_q  <= '0;
      inner_aa_q  <= '0;
      outer_div_q <= '0;
      inner_div_q <= '0;
    end else begin
      r_a_q       <= outer_radius_q;
      ri_a_q      <= ri_a_d;
      outer_sq_q  <= outer_sq_d;
      outer_aa_q  <= outer_sq_d + {{(RAD_W - 1){1'b0}}, r_a_q, 1'b0};
      inner_sq_q  <= {{RAD_W{1'b0}}, ri_a_q} * {{RAD_W{1'b0}}, ri_a_q};
      inner_aa_q  <= {{RAD_W{1'b0}}, ri_m1} * {{RAD_W{1'b0}}, ri_m1};
      outer_div_q <= {r_a_q, 1'b0};
      inner_div_q <= {ri_a_q, 1'b0} - DIV_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage ready chain
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic div_in_ready, div_out_valid;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  assign rdy6 = !v6_q || !out_stall_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || div_in_ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: canvas and enable checks, offsets from the centre
  logic             keep1;
  logic [DX_W-1:0]  dx1_d, dy1_d, dx1_q, dy1_q;
  logic [COORD_W-1:0] px1_q, py1_q;

  assign keep1 = (CMP_W'(pos_x_i) < CMP_W'(canvas_width_q))
              && (CMP_W'(pos_y_i) < CMP_W'(canvas_height_q))
              && (outer_radius_q != '0) && (ring_width_q != '0);

  assign dx1_d = {{(DX_W - COORD_W){1'b0}}, pos_x_i}
               - {{(DX_W - CTR_W){center_x_q[CTR_W-1]}}, center_x_q};
  assign dy1_d = {{(DX_W - COORD_W){1'b0}}, pos_y_i}
               - {{(DX_W - CTR_W){center_y_q[CTR_W-1]}}, center_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i && keep1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      px1_q <= pos_x_i;
      py1_q <= pos_y_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares
  logic [2*DX_W-1:0]  dx2_prod, dy2_prod;
  logic [SQ_W-1:0]    dx2_q, dy2_q;
  logic [COORD_W-1:0] px2_q, py2_q;

  assign dx2_prod = $signed(dx1_q) * $signed(dx1_q);
  assign dy2_prod = $signed(dy1_q) * $signed(dy1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      dx2_q <= dx2_prod[SQ_W-1:0];
      dy2_q <= dy2_prod[SQ_W-1:0];
      px2_q <= px1_q;
      py2_q <= py1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance
  logic [D_W-1:0]     d3_q;
  logic [COORD_W-1:0] px3_q, py3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      d3_q  <= {1'b0, dx2_q} + {1'b0, dy2_q};
      px3_q <= px2_q;
      py3_q <= py2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: classify into outer band, inner band or solid ring
  logic [D_W-1:0]   o_sq, o_aa, i_sq, i_aa, o_off, i_off;
  logic             in_ring;
  region_e          region4_d;
  logic [OFF_W-1:0] off4_d, off4_q;
  logic [DIV_W-1:0] den4_d, den4_q;
  side_t            side4_q;

  assign o_sq  = D_W'(outer_sq_q);
  assign o_aa  = D_W'(outer_aa_q);
  assign i_sq  = D_W'(inner_sq_q);
  assign i_aa  = D_W'(inner_aa_q);
  assign o_off = o_aa - d3_q;
  assign i_off = d3_q - i_aa;

  assign in_ring = (d3_q <= o_aa) && (d3_q >= i_aa);

  // outer band wins where the bands overlap
  always_comb begin
    if (d3_q >= o_sq) begin
      region4_d = REGION_OUTER;
      off4_d    = o_off[OFF_W-1:0];
      den4_d    = outer_div_q;
    end else if (d3_q <= i_sq) begin
      region4_d = REGION_INNER;
      off4_d    = i_off[OFF_W-1:0];
      den4_d    = inner_div_q;
    end else begin
      region4_d = REGION_SOLID;
      off4_d    = '0;
      den4_d    = DIV_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q && in_ring;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      off4_q         <= off4_d;
      den4_q         <= den4_d;
      side4_q.px     <= px3_q;
      side4_q.py     <= py3_q;
      side4_q.region <= region4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ramp position t = offset * 256 / range
  logic [Q_W-1:0] t_quot;
  side_t          side_div;

  arpc_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_ready_o  (div_in_ready),
    .num_i       ({off4_q, {SCALE_SH{1'b0}}}),
    .den_i       (den4_q),
    .side_i      (side4_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy5),
    .quot_o      (t_quot),
    .side_o      (side_div)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: squared ramp, t * t / 256
  logic [2*Q_W-1:0] t_sq;
  logic [Q_W-1:0]   sm5_q;
  side_t            side5_q;

  assign t_sq = {{Q_W{1'b0}}, t_quot} * {{Q_W{1'b0}}, t_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && div_out_valid) begin
      sm5_q   <= t_sq[SCALE_SH+Q_W-1:SCALE_SH];
      side5_q <= side_div;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: alpha scaled by the foreground alpha, output register
  logic [ALPHA_W-1:0]     fg;
  logic [ALPHA_W+Q_W-1:0] fg_prod;
  logic [ALPHA_W-1:0]     alpha6_d, alpha6_q;
  logic [COORD_W-1:0]     px6_q, py6_q;
  logic                   mode6_q;

  assign fg      = draw_color_q[FG_LSB +: ALPHA_W];
  assign fg_prod = {{Q_W{1'b0}}, fg} * {{ALPHA_W{1'b0}}, sm5_q};

  always_comb begin
    case (side5_q.region)
      REGION_SOLID: alpha6_d = fg;
      default:      alpha6_d = fg_prod[SCALE_SH +: ALPHA_W];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (rdy6) begin
      v6_q <= v5_q && (alpha6_d != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      alpha6_q <= alpha6_d;
      mode6_q  <= (alpha6_d != ALPHA_FULL);
      px6_q    <= side5_q.px;
      py6_q    <= side5_q.py;
    end
  end

  assign out_valid_o      = v6_q;
  assign out_x_o          = px6_q;
  assign out_y_o          = py6_q;
  assign write_mode_o     = mode6_q;
  assign coverage_alpha_o = alpha6_q;

endmodule
